// File: rtl/core/pssct_pkg.sv
// pssct_pkg: constants, field widths, codes and state type for the component table
// no dependencies
package pssct_pkg;

    localparam int NUM_TYPES      = 8;
    localparam int NUM_ENTITIES   = 1024;
    localparam int SLOTS_PER_PAGE = 64;
    localparam int VALUE_WIDTH    = 64;

    localparam int TYPE_W  = 3;
    localparam int ENT_W   = 10;
    localparam int SLOT_W  = 6;
    localparam int PAGE_W  = ENT_W - SLOT_W;
    localparam int CNT_W   = 4;
    localparam int FILL_W  = SLOT_W + 1;
    localparam int SP_W    = SLOT_W + 1;
    localparam int DN_W    = ENT_W + VALUE_WIDTH;
    localparam int SP_AW   = TYPE_W + ENT_W;
    localparam int DN_AW   = TYPE_W + PAGE_W + SLOT_W;
    localparam int FL_AW   = TYPE_W + PAGE_W;
    localparam int SP_DEPTH = NUM_TYPES * NUM_ENTITIES;
    localparam int DN_DEPTH = NUM_TYPES * (NUM_ENTITIES / SLOTS_PER_PAGE) * SLOTS_PER_PAGE;
    localparam int FL_DEPTH = NUM_TYPES * (NUM_ENTITIES / SLOTS_PER_PAGE);

    localparam int IN_W  = 80;
    localparam int OUT_W = 72;

    localparam logic [1:0] ACT_SET     = 2'd0;
    localparam logic [1:0] ACT_GET     = 2'd1;
    localparam logic [1:0] ACT_DESTROY = 2'd2;
    localparam logic [1:0] ACT_NOP     = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_ENT = 2'd1;
    localparam logic [1:0] ST_BAD_TYP = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_GETV,
        S_DLOOK,
        S_DLAST,
        S_DCLR,
        S_DONE
    } t_state;

endpackage

// File: rtl/core/paged_sparse_set_component_table.sv
// an error or no-op request goes from idle straight to done; set and get pass look, and a
// get that finds the entity also getv, before done loads the output register; destroy walks
// the types in use through dlook, adding dlast and dclr for each type holding the entity,
// in the read-modify-write sequence on the sparse, dense and fill rams. one request is
// worked at a time; a new one is taken while the last result waits. after reset a clearing
// pass wipes the sparse and fill rams; no request is taken during it, config writes are.
module paged_sparse_set_component_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0], type_id[4:2], entity[14:5], value[78:15], zero pad
    input  logic [pssct_pkg::IN_W-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], found[2], read_value[66:3], zero pad
    output logic [pssct_pkg::OUT_W-1:0] m_axis_tdata
);
    localparam int TW = pssct_pkg::TYPE_W;
    localparam int EW = pssct_pkg::ENT_W;
    localparam int SW = pssct_pkg::SLOT_W;
    localparam int PW = pssct_pkg::PAGE_W;
    localparam int VW = pssct_pkg::VALUE_WIDTH;
    localparam int CW = pssct_pkg::CNT_W;
    localparam int FW = pssct_pkg::FILL_W;
    localparam logic [CW-1:0] MAX_TYPES = CW'(pssct_pkg::NUM_TYPES);
    localparam logic [EW-1:0] ENT_LIMIT = EW'(pssct_pkg::NUM_ENTITIES - 1);
    localparam logic [FW-1:0] PAGE_FULL = FW'(pssct_pkg::SLOTS_PER_PAGE);

    pssct_pkg::t_state r_state, n_state;

    logic [pssct_pkg::SP_AW-1:0] r_clr, n_clr;
    logic [CW-1:0] r_types;
    logic [1:0]    r_act, n_act;
    logic [TW-1:0] r_type, n_type;
    logic [EW-1:0] r_ent, n_ent;
    logic [VW-1:0] r_val, n_val;
    logic          r_found, n_found;
    logic [1:0]    r_status, n_status;
    logic [VW-1:0] r_rd, n_rd;
    logic [SW-1:0] r_hole, n_hole;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_o_valid, n_o_valid;
    logic [pssct_pkg::OUT_W-1:0] r_o_data, n_o_data;

    logic                         sp_we, dn_we, fl_we;
    logic [pssct_pkg::SP_AW-1:0]  sp_waddr, sp_raddr;
    logic [pssct_pkg::DN_AW-1:0]  dn_waddr, dn_raddr;
    logic [pssct_pkg::FL_AW-1:0]  fl_waddr, fl_raddr;
    logic [pssct_pkg::SP_W-1:0]   sp_wdata, sp_rdata;
    logic [pssct_pkg::DN_W-1:0]   dn_wdata, dn_rdata;
    logic [FW-1:0]                fl_wdata, fl_rdata;

    logic [1:0]    in_act;
    logic [TW-1:0] in_type, rd_type;
    logic [EW-1:0] in_ent;
    logic [VW-1:0] in_val;
    logic [CW-1:0] active, next_type;
    logic          accept, hit, adv, more, out_free;
    logic [PW-1:0] page;

    assign in_act  = s_axis_tdata[1:0];
    assign in_type = s_axis_tdata[4:2];
    assign in_ent  = s_axis_tdata[14:5];
    assign in_val  = s_axis_tdata[78:15];

    assign active    = (r_types > MAX_TYPES) ? MAX_TYPES : r_types;
    assign s_axis_tready = (r_state == pssct_pkg::S_IDLE);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign page      = r_ent[EW-1:SW];
    assign hit       = sp_rdata[SW] && (fl_rdata != '0);
    assign adv       = (r_state == pssct_pkg::S_DLOOK && !hit) || r_state == pssct_pkg::S_DCLR;
    assign next_type = {1'b0, r_type} + CW'(1);
    assign more      = next_type < active;
    assign out_free  = !r_o_valid || m_axis_tready;
    assign rd_type   = (in_act == pssct_pkg::ACT_DESTROY) ? '0 : in_type;

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

    pssct_ram #(.WIDTH(pssct_pkg::SP_W), .DEPTH(pssct_pkg::SP_DEPTH)) u_sparse (
        .i_clk(i_clk), .i_we(sp_we), .i_waddr(sp_waddr), .i_wdata(sp_wdata),
        .i_raddr(sp_raddr), .o_rdata(sp_rdata));
    pssct_ram #(.WIDTH(pssct_pkg::DN_W), .DEPTH(pssct_pkg::DN_DEPTH)) u_dense (
        .i_clk(i_clk), .i_we(dn_we), .i_waddr(dn_waddr), .i_wdata(dn_wdata),
        .i_raddr(dn_raddr), .o_rdata(dn_rdata));
    pssct_ram #(.WIDTH(FW), .DEPTH(pssct_pkg::FL_DEPTH)) u_fill (
        .i_clk(i_clk), .i_we(fl_we), .i_waddr(fl_waddr), .i_wdata(fl_wdata),
        .i_raddr(fl_raddr), .o_rdata(fl_rdata));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pssct_pkg::S_CLEAR: begin
                if (r_clr == '1) n_state = pssct_pkg::S_IDLE;
            end
            pssct_pkg::S_IDLE: begin
                if (accept) begin
                    if (in_act == pssct_pkg::ACT_NOP || in_ent >= ENT_LIMIT) begin
                        n_state = pssct_pkg::S_DONE;
                    end else if (in_act == pssct_pkg::ACT_DESTROY) begin
                        n_state = (active == '0) ? pssct_pkg::S_DONE : pssct_pkg::S_DLOOK;
                    end else if ({1'b0, in_type} >= active) begin
                        n_state = pssct_pkg::S_DONE;
                    end else begin
                        n_state = pssct_pkg::S_LOOK;
                    end
                end
            end
            pssct_pkg::S_LOOK: begin
                n_state = (sp_rdata[SW] && r_act == pssct_pkg::ACT_GET) ?
                          pssct_pkg::S_GETV : pssct_pkg::S_DONE;
            end
            pssct_pkg::S_GETV: n_state = pssct_pkg::S_DONE;
            pssct_pkg::S_DLOOK: begin
                if (hit) n_state = pssct_pkg::S_DLAST;
                else     n_state = more ? pssct_pkg::S_DLOOK : pssct_pkg::S_DONE;
            end
            pssct_pkg::S_DLAST: n_state = pssct_pkg::S_DCLR;
            pssct_pkg::S_DCLR:  n_state = more ? pssct_pkg::S_DLOOK : pssct_pkg::S_DONE;
            pssct_pkg::S_DONE: begin
                if (out_free) n_state = pssct_pkg::S_IDLE;
            end
            default: n_state = pssct_pkg::S_IDLE;
        endcase
    end

    // memory controls and datapath
    always_comb begin
        n_clr    = r_clr;
        n_act    = r_act;
        n_type   = r_type;
        n_ent    = r_ent;
        n_val    = r_val;
        n_found  = r_found;
        n_status = r_status;
        n_rd     = r_rd;
        n_hole   = r_hole;
        n_fill   = r_fill;
        n_o_valid = r_o_valid && !m_axis_tready;
        n_o_data  = r_o_data;
        sp_we = 1'b0; sp_waddr = {r_type, r_ent}; sp_wdata = '0;
        dn_we = 1'b0; dn_waddr = {r_type, page, r_hole}; dn_wdata = {r_ent, r_val};
        fl_we = 1'b0; fl_waddr = {r_type, page}; fl_wdata = '0;
        sp_raddr = {r_type, r_ent};
        fl_raddr = {r_type, page};
        dn_raddr = {r_type, page, sp_rdata[SW-1:0]};
        if (adv) begin
            n_type   = next_type[TW-1:0];
            sp_raddr = {next_type[TW-1:0], r_ent};
            fl_raddr = {next_type[TW-1:0], page};
        end
        unique case (r_state)
            pssct_pkg::S_CLEAR: begin
                n_clr    = r_clr + 1'b1;
                sp_we    = 1'b1;
                sp_waddr = r_clr;
                fl_we    = 1'b1;
                fl_waddr = r_clr[pssct_pkg::FL_AW-1:0];
            end
            pssct_pkg::S_IDLE: begin
                sp_raddr = {rd_type, in_ent};
                fl_raddr = {rd_type, in_ent[EW-1:SW]};
                if (accept) begin
                    n_act    = in_act;
                    n_type   = rd_type;
                    n_ent    = in_ent;
                    n_val    = in_val;
                    n_found  = 1'b0;
                    n_rd     = '0;
                    if (in_act == pssct_pkg::ACT_NOP) begin
                        n_status = pssct_pkg::ST_OK;
                    end else if (in_ent >= ENT_LIMIT) begin
                        n_status = pssct_pkg::ST_BAD_ENT;
                    end else if (in_act != pssct_pkg::ACT_DESTROY && {1'b0, in_type} >= active) begin
                        n_status = pssct_pkg::ST_BAD_TYP;
                    end else begin
                        n_status = pssct_pkg::ST_OK;
                    end
                end
            end
            pssct_pkg::S_LOOK: begin
                if (sp_rdata[SW]) begin
                    n_found = 1'b1;
                    if (r_act == pssct_pkg::ACT_SET) begin
                        dn_we    = 1'b1;
                        dn_waddr = {r_type, page, sp_rdata[SW-1:0]};
                    end
                end else if (r_act == pssct_pkg::ACT_SET && fl_rdata < PAGE_FULL) begin
                    // append at the end of the page
                    sp_we    = 1'b1;
                    sp_wdata = {1'b1, fl_rdata[SW-1:0]};
                    dn_we    = 1'b1;
                    dn_waddr = {r_type, page, fl_rdata[SW-1:0]};
                    fl_we    = 1'b1;
                    fl_wdata = fl_rdata + 1'b1;
                end
            end
            pssct_pkg::S_GETV: n_rd = dn_rdata[VW-1:0];
            pssct_pkg::S_DLOOK: begin
                if (hit) begin
                    n_found  = 1'b1;
                    n_hole   = sp_rdata[SW-1:0];
                    n_fill   = fl_rdata;
                    dn_raddr = {r_type, page, SW'(fl_rdata - 1'b1)};
                end
            end
            pssct_pkg::S_DLAST: begin
                // last entry moves into the hole
                dn_we    = 1'b1;
                dn_wdata = dn_rdata;
                sp_we    = 1'b1;
                sp_waddr = {r_type, dn_rdata[pssct_pkg::DN_W-1:VW]};
                sp_wdata = {1'b1, r_hole};
                fl_we    = 1'b1;
                fl_wdata = r_fill - 1'b1;
            end
            pssct_pkg::S_DCLR: begin
                sp_we = 1'b1;
            end
            pssct_pkg::S_DONE: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_data  = {5'd0, r_rd, r_found, r_status};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pssct_pkg::S_CLEAR;
            r_clr     <= '0;
            r_types   <= CW'(1);
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) r_types <= i_cfg_wdata;
        end
        r_act    <= n_act;
        r_type   <= n_type;
        r_ent    <= n_ent;
        r_val    <= n_val;
        r_found  <= n_found;
        r_status <= n_status;
        r_rd     <= n_rd;
        r_hole   <= n_hole;
        r_fill   <= n_fill;
        r_o_data <= n_o_data;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fl_we && r_state != pssct_pkg::S_CLEAR) |-> fl_wdata <= PAGE_FULL)
        else $error("page fill beyond page size");
    a_move_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pssct_pkg::S_DLAST) |-> (sp_we && sp_wdata[SW]))
        else $error("moved entity not marked present");
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pssct_pkg::S_DLOOK) |-> ({1'b0, r_type} < active))
        else $error("destroy walk past types in use");
    a_accept_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != pssct_pkg::S_IDLE)
        else $error("request accepted but not worked");
`endif
endmodule

// File: rtl/core/pssct_ram.sv
// pssct_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
module pssct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: test/paged_sparse_set_component_table_tb.sv
// testbench for paged_sparse_set_component_table: random set/get/destroy requests
// checked against a behavioral model of the paged sparse sets; depends on pssct_pkg
module paged_sparse_set_component_table_tb;

    localparam int N_TYPES = pssct_pkg::NUM_TYPES;
    localparam int N_ENTS  = pssct_pkg::NUM_ENTITIES;
    localparam int N_SLOTS = pssct_pkg::SLOTS_PER_PAGE;
    localparam int N_PAGES = N_ENTS / N_SLOTS;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [63:0] rdval;
    } t_resp;

    class table_scoreboard;
        int unsigned tiu;
        bit          present [N_TYPES][N_ENTS];
        int unsigned slot_of [N_TYPES][N_ENTS];
        int unsigned ent_of  [N_TYPES][N_PAGES][N_SLOTS];
        logic [63:0] val_of  [N_TYPES][N_PAGES][N_SLOTS];
        int unsigned fill    [N_TYPES][N_PAGES];
        t_resp       pending[$];
        int          errors;
        int          checked;

        function new();
            tiu = 1;
            errors = 0;
            checked = 0;
            foreach (present[t, e]) begin
                present[t][e] = 0;
                slot_of[t][e] = 0;
            end
            foreach (fill[t, p]) fill[t][p] = 0;
        endfunction

        function int unsigned active();
            return (tiu > N_TYPES) ? N_TYPES : tiu;
        endfunction

        function bit drop(int unsigned t, int unsigned e);
            int unsigned pg, hole, last, mv;
            pg = e / N_SLOTS;
            if (!present[t][e] || fill[t][pg] == 0) return 0;
            hole = slot_of[t][e];
            last = fill[t][pg] - 1;
            mv = ent_of[t][pg][last];
            val_of[t][pg][hole] = val_of[t][pg][last];
            ent_of[t][pg][hole] = mv;
            slot_of[t][mv] = hole;
            present[t][e] = 0;
            fill[t][pg] = last;
            return 1;
        endfunction

        function void note_request(logic [79:0] d);
            logic [1:0]  act;
            int unsigned t, e, pg, s;
            logic [63:0] v;
            t_resp       r;
            act = d[1:0];
            t = d[4:2];
            e = d[14:5];
            v = d[78:15];
            r = '0;
            pg = e / N_SLOTS;
            if (act == pssct_pkg::ACT_NOP) begin
                // unused action: no change
            end else if (e >= N_ENTS - 1) begin
                r.status = pssct_pkg::ST_BAD_ENT;
            end else if (act == pssct_pkg::ACT_DESTROY) begin
                for (int i = 0; i < active(); i++)
                    if (drop(i, e)) r.found = 1;
            end else if (t >= active()) begin
                r.status = pssct_pkg::ST_BAD_TYP;
            end else if (present[t][e]) begin
                r.found = 1;
                if (act == pssct_pkg::ACT_SET) val_of[t][pg][slot_of[t][e]] = v;
                else r.rdval = val_of[t][pg][slot_of[t][e]];
            end else if (act == pssct_pkg::ACT_SET && fill[t][pg] < N_SLOTS) begin
                s = fill[t][pg];
                present[t][e] = 1;
                slot_of[t][e] = s;
                ent_of[t][pg][s] = e;
                val_of[t][pg][s] = v;
                fill[t][pg] = s + 1;
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [71:0] d);
            t_resp x;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: result with none expected: %h", $time, d);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (d[1:0] !== x.status) begin
                $display("%0t: status exp %0d act %0d", $time, x.status, d[1:0]);
                errors++;
            end
            if (d[2] !== x.found) begin
                $display("%0t: found exp %0d act %0d", $time, x.found, d[2]);
                errors++;
            end
            if (d[66:3] !== x.rdval) begin
                $display("%0t: read_value exp %h act %h", $time, x.rdval, d[66:3]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;

    paged_sparse_set_component_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    table_scoreboard sb;
    bit          gaps_on;
    int          long_hold;
    int unsigned cycle_cnt;
    int          n_sent;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // the whole run should finish well inside this
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > 600000) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // result side: random stall bursts, plus one long hold-off
    initial begin
        int burst;
        m_axis_tready = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold > 0) begin
                m_axis_tready <= 0;
                long_hold--;
            end else if (gaps_on && burst > 0) begin
                m_axis_tready <= 0;
                burst--;
            end else begin
                m_axis_tready <= 1;
                if (gaps_on && $urandom_range(0, 9) == 0) burst = $urandom_range(1, 14);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    task automatic send_request(logic [1:0] act, logic [2:0] t, logic [9:0] e,
                                logic [63:0] v);
        int gap;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {1'b0, v, e, t, act};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request({1'b0, v, e, t, act});
        n_sent++;
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        // let the design sit quiet before any config write
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_types(logic [3:0] n);
        i_cfg_we    <= 1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.tiu = n;
    endtask

    // mostly valid entities in a few pages so pages fill and swap-remove happens
    function automatic logic [9:0] pick_entity();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 10'($urandom_range(1023, 1023));
        if (r == 1) return 10'($urandom_range(0, 1022));
        if (r < 10) return 10'($urandom_range(0, 69));
        return 10'($urandom_range(960, 1022));
    endfunction

    task automatic random_phase(int n, int max_t);
        logic [1:0] act;
        int         r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 19);
            act = (r < 9) ? pssct_pkg::ACT_SET : (r < 15) ? pssct_pkg::ACT_GET :
                  (r < 19) ? pssct_pkg::ACT_DESTROY : pssct_pkg::ACT_NOP;
            send_request(act, 3'($urandom_range(0, max_t)), pick_entity(),
                         {$urandom, $urandom});
        end
    endtask

    initial begin
        sb = new();
        gaps_on = 1;
        long_hold = 0;
        n_sent = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_wdata = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, every action, error ordering
        send_request(pssct_pkg::ACT_GET, 0, 0, 0);
        send_request(pssct_pkg::ACT_SET, 0, 0, '1);
        send_request(pssct_pkg::ACT_GET, 0, 0, 0);
        send_request(pssct_pkg::ACT_SET, 0, 0, 64'h5555_aaaa_0f0f_f0f0);
        send_request(pssct_pkg::ACT_GET, 0, 0, 0);
        send_request(pssct_pkg::ACT_SET, 0, 1022, 64'h1);
        send_request(pssct_pkg::ACT_SET, 0, 1023, '1);
        send_request(pssct_pkg::ACT_GET, 7, 1023, 0);
        send_request(pssct_pkg::ACT_SET, 7, 5, '1);
        send_request(pssct_pkg::ACT_GET, 1, 0, 0);
        send_request(pssct_pkg::ACT_NOP, 7, 1023, '1);
        send_request(pssct_pkg::ACT_SET, 0, 1, 64'h2);
        send_request(pssct_pkg::ACT_SET, 0, 2, 64'h3);
        send_request(pssct_pkg::ACT_DESTROY, 0, 0, 0);
        send_request(pssct_pkg::ACT_GET, 0, 2, 0);
        send_request(pssct_pkg::ACT_GET, 0, 1, 0);
        send_request(pssct_pkg::ACT_DESTROY, 7, 0, 0);
        send_request(pssct_pkg::ACT_DESTROY, 0, 1023, 0);
        go_idle();

        write_types(0);
        send_request(pssct_pkg::ACT_SET, 0, 3, 64'h9);
        send_request(pssct_pkg::ACT_DESTROY, 0, 1022, 0);
        go_idle();
        write_types(8);
        send_request(pssct_pkg::ACT_SET, 7, 1022, 64'h77);
        send_request(pssct_pkg::ACT_GET, 7, 1022, 0);
        send_request(pssct_pkg::ACT_DESTROY, 3, 1022, 0);

        // fill one page completely and spill into the next
        for (int i = 0; i < 66; i++)
            send_request(pssct_pkg::ACT_SET, 2, 10'(i), {$urandom, $urandom});
        random_phase(300, 7);

        // receiver stalls long while requests keep coming
        long_hold = 300;
        random_phase(40, 7);
        go_idle();
        write_types(15);
        random_phase(250, 7);
        go_idle();
        write_types(3);
        random_phase(200, 4);
        go_idle();
        write_types(4'($urandom_range(1, 8)));
        gaps_on = 0;
        random_phase(200, 7);
        go_idle();

        $display("sent %0d requests, checked %0d results, types_in_use 0, 3, 8, 15 and random",
                 n_sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
